FILE: rtl/assert_macros.svh
// Assertion helpers, clocked on clk and disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every edge.
`define ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition followed by a consequence at the next edge.
`define ASSERT_NEXT(name, cond, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) else $error(msg);

`endif

FILE: rtl/dmic_pkg.sv
`timescale 1ns / 1ps

package dmic_pkg;

    localparam int INDEX_BITS_DEF = 8;
    localparam int LINE_BITS      = 5;
    localparam int WSEL_BITS      = LINE_BITS - 2;

    localparam logic [1:0] CMD_FETCH    = 2'd0;
    localparam logic [1:0] CMD_FILL     = 2'd1;
    localparam logic [1:0] CMD_INV_ALL  = 2'd2;
    localparam logic [1:0] CMD_INV_ADDR = 2'd3;

    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_MISS     = 2'd1;
    localparam logic [1:0] ST_ALIGN    = 2'd2;
    localparam logic [1:0] ST_FILL_ERR = 2'd3;

    localparam logic [3:0] FAULT_NONE  = 4'h0;
    localparam logic [3:0] FAULT_ALIGN = 4'h3;
    localparam logic [3:0] FAULT_FILL  = 4'hd;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] address;
        logic [1:0]  size_code;
        logic [2:0]  fill_word_index;
        logic [31:0] fill_data;
        logic        fill_last;
        logic        fill_error;
    } ic_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  fault_code;
        logic [31:0] read_data;
    } ic_rsp_t;

endpackage

FILE: rtl/direct_mapped_icache_core.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Direct-mapped instruction cache, 32-byte lines of eight words. One word is
// taken per cycle unless stalled; each gives a response word through the
// lookup and output registers. Tag and line stores are synchronous, read at
// acceptance and compared in the following cycle. An invalidate by address
// stalls input in lookup, as the valid bit is cleared only after the stored
// tag is read back. Valid bits are flip-flops cleared by reset, so no clearing
// pass is needed; data and tags of a line are undefined until it is refilled.
module direct_mapped_icache_core
#(
    parameter int INDEX_BITS = dmic_pkg::INDEX_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  dmic_pkg::ic_req_t cmd_word,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output dmic_pkg::ic_rsp_t rsp_word
);
    import dmic_pkg::*;

    localparam int NUM_LINES  = 1 << INDEX_BITS;
    localparam int TAG_BITS   = 32 - LINE_BITS - INDEX_BITS;
    localparam int DATA_DEPTH = NUM_LINES << WSEL_BITS;

    logic [TAG_BITS-1:0]   tag_mem  [NUM_LINES];
    logic [31:0]           data_mem [DATA_DEPTH];

    logic [NUM_LINES-1:0]  valid_reg, valid_next;
    logic                  fill_bad_reg, fill_bad_next;

    logic                  s1_valid_reg;
    logic [1:0]            s1_cmd_reg;
    logic [INDEX_BITS-1:0] s1_idx_reg;
    logic [TAG_BITS-1:0]   s1_tag_reg;
    logic [1:0]            s1_off_reg;
    logic [1:0]            s1_size_reg;
    logic                  s1_lookup_reg;
    logic                  s1_line_valid_reg;
    logic [1:0]            s1_status_reg;
    logic [3:0]            s1_fault_reg;
    logic [TAG_BITS-1:0]   tag_rd_reg;
    logic [31:0]           data_rd_reg;

    logic                  rsp_valid_reg;
    ic_rsp_t               rsp_word_reg, rsp_word_next;

    logic                  cmd_accept;
    logic                  s1_adv;
    logic                  s1_hit;
    logic [INDEX_BITS-1:0] acc_idx;
    logic [TAG_BITS-1:0]   acc_tag;
    logic [WSEL_BITS-1:0]  acc_wsel;
    logic                  acc_misaligned;
    logic                  acc_fill;
    logic                  acc_bad;
    logic                  acc_commit;
    logic [1:0]            acc_status;
    logic [3:0]            acc_fault;
    logic [31:0]           shifted;

    assign cmd_accept = cmd_valid & ~cmd_stall;
    assign s1_adv     = s1_valid_reg & (~rsp_valid_reg | ~rsp_stall);
    assign cmd_stall  = s1_valid_reg & (~s1_adv | (s1_cmd_reg == CMD_INV_ADDR));

    assign acc_idx  = cmd_word.address[LINE_BITS +: INDEX_BITS];
    assign acc_tag  = cmd_word.address[31 -: TAG_BITS];
    assign acc_wsel = cmd_word.address[LINE_BITS-1:2];

    always_comb
    begin
        case (cmd_word.size_code)
            SIZE_BYTE: acc_misaligned = 1'b0;
            SIZE_HALF: acc_misaligned = cmd_word.address[0];
            default:   acc_misaligned = |cmd_word.address[1:0];
        endcase
    end

    assign acc_fill   = cmd_word.command == CMD_FILL;
    assign acc_bad    = fill_bad_reg | cmd_word.fill_error;
    assign acc_commit = acc_fill & cmd_word.fill_last & ~acc_bad;

    always_comb
    begin
        acc_status = ST_OK;
        acc_fault  = FAULT_NONE;
        case (cmd_word.command)
            CMD_FETCH:
            begin
                if (acc_misaligned)
                begin
                    acc_status = ST_ALIGN;
                    acc_fault  = FAULT_ALIGN;
                end
            end
            CMD_FILL:
            begin
                if (cmd_word.fill_error | (cmd_word.fill_last & acc_bad))
                begin
                    acc_status = ST_FILL_ERR;
                    acc_fault  = FAULT_FILL;
                end
            end
            default:
            begin
                acc_status = ST_OK;
            end
        endcase
    end

    // memories: read at acceptance, fill writes land at the same edge
    always_ff @(posedge clk)
    begin
        if (cmd_accept)
        begin
            tag_rd_reg  <= tag_mem[acc_idx];
            data_rd_reg <= data_mem[{acc_idx, acc_wsel}];
            if (acc_fill & ~cmd_word.fill_error)
            begin
                data_mem[{acc_idx, cmd_word.fill_word_index}] <= cmd_word.fill_data;
            end
            if (acc_commit)
            begin
                tag_mem[acc_idx] <= acc_tag;
            end
        end
    end

    assign s1_hit = s1_line_valid_reg & (tag_rd_reg == s1_tag_reg);

    always_comb
    begin
        valid_next    = valid_reg;
        fill_bad_next = fill_bad_reg;
        if (cmd_accept)
        begin
            case (cmd_word.command)
                CMD_FILL:
                begin
                    valid_next[acc_idx] = acc_commit;
                    fill_bad_next       = acc_bad & ~cmd_word.fill_last;
                end
                CMD_INV_ALL:
                begin
                    valid_next = '0;
                end
                default:
                begin
                    fill_bad_next = fill_bad_reg;
                end
            endcase
        end
        if (s1_valid_reg && (s1_cmd_reg == CMD_INV_ADDR) && s1_hit)
        begin
            valid_next[s1_idx_reg] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            fill_bad_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            fill_bad_reg  <= fill_bad_next;
            s1_valid_reg  <= cmd_accept | (s1_valid_reg & ~s1_adv);
            rsp_valid_reg <= s1_adv | (rsp_valid_reg & rsp_stall);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_accept)
        begin
            s1_cmd_reg        <= cmd_word.command;
            s1_idx_reg        <= acc_idx;
            s1_tag_reg        <= acc_tag;
            s1_off_reg        <= cmd_word.address[1:0];
            s1_size_reg       <= cmd_word.size_code;
            s1_lookup_reg     <= (cmd_word.command == CMD_FETCH) & ~acc_misaligned;
            s1_line_valid_reg <= valid_reg[acc_idx];
            s1_status_reg     <= acc_status;
            s1_fault_reg      <= acc_fault;
        end
        if (s1_adv)
        begin
            rsp_word_reg <= rsp_word_next;
        end
    end

    assign shifted = data_rd_reg >> {s1_off_reg, 3'b000};

    always_comb
    begin
        rsp_word_next.status     = s1_status_reg;
        rsp_word_next.fault_code = s1_fault_reg;
        rsp_word_next.read_data  = 32'd0;
        if (s1_lookup_reg)
        begin
            if (s1_hit)
            begin
                case (s1_size_reg)
                    SIZE_BYTE: rsp_word_next.read_data = {24'd0, shifted[7:0]};
                    SIZE_HALF: rsp_word_next.read_data = {16'd0, shifted[15:0]};
                    default:   rsp_word_next.read_data = shifted;
                endcase
            end
            else
            begin
                rsp_word_next.status = ST_MISS;
            end
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

    `ASSERT_ALWAYS(a_inv_addr_blocks, (s1_valid_reg && (s1_cmd_reg == CMD_INV_ADDR)) |-> cmd_stall, "input taken behind invalidate-by-address")
    `ASSERT_NEXT(a_s1_held, s1_valid_reg && !s1_adv, s1_valid_reg, "lookup stage word lost")
    `ASSERT_NEXT(a_inv_all, cmd_accept && (cmd_word.command == CMD_INV_ALL), valid_reg == '0, "valid bits survive invalidate-all")
    `ASSERT_NEXT(a_fill_commit, cmd_accept && acc_commit, valid_reg[$past(acc_idx)], "refilled line not valid")
    `ASSERT_ALWAYS(a_align_fault, (rsp_valid && (rsp_word.status == ST_ALIGN)) |-> (rsp_word.fault_code == FAULT_ALIGN), "alignment response without its fault code")

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import dmic_pkg::*;

    localparam int INDEX_BITS = INDEX_BITS_DEF;
    localparam int NUM_LINES  = 1 << INDEX_BITS;
    localparam int TAG_BITS   = 32 - LINE_BITS - INDEX_BITS;
    localparam int N_RANDOM   = 1000;

    typedef struct {
        ic_req_t word;
        bit      hold;
    } backlog_t;

    logic    clk       = 1'b0;
    logic    rst_n     = 1'b0;
    logic    cmd_valid = 1'b0;
    logic    cmd_stall;
    ic_req_t cmd_word  = '0;
    logic    rsp_valid;
    logic    rsp_stall = 1'b0;
    ic_rsp_t rsp_word;

    backlog_t cmd_backlog[$];
    ic_rsp_t  rsp_due[$];
    ic_rsp_t  due_rsp;
    int       n_errors = 0;

    // predicted cache contents
    logic [31:0]         line_data [NUM_LINES * 8];
    logic [TAG_BITS-1:0] line_tag  [NUM_LINES];
    bit                  line_vld  [NUM_LINES];
    bit                  refill_bad;

    // stimulus bookkeeping: which store words have ever been written
    bit                    word_filled [NUM_LINES * 8];
    logic [31:0]           recent_lines[$];
    logic [TAG_BITS-1:0]   tag_pool [4];
    logic [INDEX_BITS-1:0] idx_pool [8];

    int burst_left = 0;
    int gap_left   = 0;
    int stall_mode = 0;
    int mode_left  = 0;
    int stall_tick = 0;

    direct_mapped_icache_core i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_word  (cmd_word),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word)
    );

    function automatic ic_rsp_t icache_response(ic_req_t w);
        ic_rsp_t               r;
        logic [INDEX_BITS-1:0] idx;
        logic [TAG_BITS-1:0]   tg;
        logic [31:0]           data;
        int unsigned           nbytes;
        bit                    bad;
        r.status     = ST_OK;
        r.fault_code = FAULT_NONE;
        r.read_data  = '0;
        idx = w.address[LINE_BITS +: INDEX_BITS];
        tg  = w.address[31 -: TAG_BITS];
        case (w.command)
            CMD_FETCH:
            begin
                nbytes = (w.size_code == SIZE_BYTE) ? 1 : (w.size_code == SIZE_HALF) ? 2 : 4;
                if ((w.address & (nbytes - 1)) != 0)
                begin
                    r.status     = ST_ALIGN;
                    r.fault_code = FAULT_ALIGN;
                end
                else if (!line_vld[idx] || line_tag[idx] != tg)
                begin
                    r.status = ST_MISS;
                end
                else
                begin
                    data = line_data[{idx, w.address[LINE_BITS-1:2]}] >> (8 * w.address[1:0]);
                    if (nbytes == 1)
                        data &= 32'h0000_00ff;
                    else if (nbytes == 2)
                        data &= 32'h0000_ffff;
                    r.read_data = data;
                end
            end
            CMD_FILL:
            begin
                line_vld[idx] = 1'b0;
                if (w.fill_error)
                    refill_bad = 1'b1;
                else
                    line_data[{idx, w.fill_word_index}] = w.fill_data;
                bad = refill_bad;
                if (w.fill_last)
                begin
                    if (!bad)
                    begin
                        line_tag[idx] = tg;
                        line_vld[idx] = 1'b1;
                    end
                    refill_bad = 1'b0;
                end
                if (w.fill_error || (w.fill_last && bad))
                begin
                    r.status     = ST_FILL_ERR;
                    r.fault_code = FAULT_FILL;
                end
            end
            CMD_INV_ALL:
            begin
                foreach (line_vld[i])
                    line_vld[i] = 1'b0;
            end
            CMD_INV_ADDR:
            begin
                if (line_vld[idx] && line_tag[idx] == tg)
                    line_vld[idx] = 1'b0;
            end
        endcase
        return r;
    endfunction

    function automatic ic_req_t make_req(logic [1:0] cmd, logic [31:0] addr, logic [1:0] sz,
                                         logic [2:0] widx, logic [31:0] data, bit last,
                                         bit err);
        ic_req_t w;
        w.command         = cmd;
        w.address         = addr;
        w.size_code       = sz;
        w.fill_word_index = widx;
        w.fill_data       = data;
        w.fill_last       = last;
        w.fill_error      = err;
        return w;
    endfunction

    function automatic void send(ic_req_t w, bit hold);
        backlog_t b;
        if (w.command == CMD_FILL && !w.fill_error)
            word_filled[{w.address[LINE_BITS +: INDEX_BITS], w.fill_word_index}] = 1'b1;
        b.word = w;
        b.hold = hold;
        cmd_backlog.push_back(b);
    endfunction

    // a clean last word may only validate a line whose every word has been written
    function automatic bit line_complete(logic [31:0] addr, logic [2:0] widx);
        for (int k = 0; k < 8; k++)
            if (k != widx && !word_filled[{addr[LINE_BITS +: INDEX_BITS], 3'(k)}])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [31:0] pick_address();
        logic [TAG_BITS-1:0]   tg;
        logic [INDEX_BITS-1:0] idx;
        tg  = ($urandom_range(3) == 0) ? TAG_BITS'($urandom) : tag_pool[$urandom_range(3)];
        idx = ($urandom_range(1) == 0) ? INDEX_BITS'($urandom) : idx_pool[$urandom_range(7)];
        return {tg, idx, LINE_BITS'($urandom)};
    endfunction

    function automatic logic [31:0] near_address();
        logic [31:0] base;
        if (recent_lines.size() != 0 && $urandom_range(9) < 7)
        begin
            base = recent_lines[$urandom_range(recent_lines.size() - 1)];
            return {base[31:LINE_BITS], LINE_BITS'($urandom)};
        end
        return pick_address();
    endfunction

    function automatic void refill_line(logic [31:0] base, bit complete);
        int order [8];
        int n_words;
        int bad_pos;
        int j;
        int t;
        bit err;
        bit last;
        bit err_seen;
        foreach (order[i])
            order[i] = i;
        for (int i = 7; i > 0; i--)
        begin
            j        = $urandom_range(i);
            t        = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        n_words  = complete ? 8 : $urandom_range(1, 7);
        bad_pos  = ($urandom_range(5) == 0) ? $urandom_range(n_words - 1) : -1;
        err_seen = 1'b0;
        for (int i = 0; i < n_words; i++)
        begin
            err  = (i == bad_pos);
            last = complete && (i == 7);
            if (last && !err && !err_seen && !line_complete(base, 3'(order[i])))
                err = 1'b1;
            send(make_req(CMD_FILL, base, 2'($urandom), 3'(order[i]), $urandom, last, err),
                 1'b0);
            err_seen |= err;
        end
        if (complete)
        begin
            recent_lines.push_back(base);
            if (recent_lines.size() > 8)
                void'(recent_lines.pop_front());
        end
    endfunction

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
            cmd_word  <= '0;
        end
        else
        begin
            if (cmd_valid && !cmd_stall)
            begin
                rsp_due.push_back(icache_response(cmd_word));
                void'(cmd_backlog.pop_front());
            end
            if (!cmd_valid || !cmd_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    cmd_valid <= 1'b0;
                end
                else if (cmd_backlog.size() == 0
                         || (cmd_backlog[0].hold && rsp_due.size() != 0))
                begin
                    cmd_valid <= 1'b0;
                end
                else
                begin
                    cmd_valid <= 1'b1;
                    cmd_word  <= cmd_backlog[0].word;
                    if (burst_left > 0)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
    end

    // response stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(3);
                mode_left  = $urandom_range(32, 200);
            end
            else
            begin
                mode_left--;
            end
            stall_tick++;
            case (stall_mode)
                0:       rsp_stall <= 1'b0;
                1:       rsp_stall <= ($urandom_range(9) < 3);
                2:       rsp_stall <= ($urandom_range(9) < 8);
                default: rsp_stall <= (stall_tick % 4) != 0;
            endcase
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (rsp_due.size() == 0)
            begin
                $error("response word with nothing outstanding");
                n_errors++;
            end
            else
            begin
                due_rsp = rsp_due.pop_front();
                if (rsp_word.status !== due_rsp.status)
                begin
                    $error("status: expected %0d, got %0d", due_rsp.status, rsp_word.status);
                    n_errors++;
                end
                if (rsp_word.fault_code !== due_rsp.fault_code)
                begin
                    $error("fault_code: expected %0d, got %0d",
                           due_rsp.fault_code, rsp_word.fault_code);
                    n_errors++;
                end
                if (rsp_word.read_data !== due_rsp.read_data)
                begin
                    $error("read_data: expected %h, got %h",
                           due_rsp.read_data, rsp_word.read_data);
                    n_errors++;
                end
            end
        end
    end

    initial
    begin
        int          r;
        int          n_target;
        logic [31:0] a;
        logic [1:0]  sz;
        bit          last;
        bit          err;

        foreach (tag_pool[i])
            tag_pool[i] = TAG_BITS'($urandom);
        foreach (idx_pool[i])
            idx_pool[i] = INDEX_BITS'($urandom);

        // cold miss and alignment faults, size code three included
        send(make_req(CMD_FETCH, 32'h0000_0000, SIZE_BYTE, '0, '0, 1'b0, 1'b0), 1'b0);
        send(make_req(CMD_FETCH, 32'h0000_0001, SIZE_HALF, '0, '0, 1'b0, 1'b0), 1'b0);
        send(make_req(CMD_FETCH, 32'h0000_0002, 2'd2, '0, '0, 1'b0, 1'b0), 1'b0);
        send(make_req(CMD_FETCH, 32'h0000_0006, 2'd3, '0, '0, 1'b0, 1'b0), 1'b0);
        // refill the topmost line, then hits at the top of the address space
        for (int k = 0; k < 8; k++)
            send(make_req(CMD_FILL, 32'hffff_ffe0, SIZE_BYTE, 3'(k),
                          (k == 0) ? 32'hffff_ffff : (k == 1) ? 32'h0 : (k == 7) ? 32'ha5c3_0f81
                                                                            : $urandom,
                          k == 7, 1'b0), 1'b0);
        send(make_req(CMD_FETCH, 32'hffff_ffff, SIZE_BYTE, '0, '0, 1'b0, 1'b0), 1'b1);
        send(make_req(CMD_FETCH, 32'hffff_fffe, SIZE_HALF, '0, '0, 1'b0, 1'b0), 1'b0);
        send(make_req(CMD_FETCH, 32'hffff_ffe0, 2'd2, '0, '0, 1'b0, 1'b0), 1'b0);
        send(make_req(CMD_FETCH, 32'hffff_ffe4, 2'd3, '0, '0, 1'b0, 1'b0), 1'b0);
        // invalidate by address: wrong tag first, then the real one
        send(make_req(CMD_INV_ADDR, 32'h0000_1fe0, SIZE_BYTE, '0, '0, 1'b0, 1'b0), 1'b0);
        send(make_req(CMD_FETCH, 32'hffff_ffe0, 2'd2, '0, '0, 1'b0, 1'b0), 1'b0);
        send(make_req(CMD_INV_ADDR, 32'hffff_fff0, SIZE_BYTE, '0, '0, 1'b0, 1'b0), 1'b0);
        send(make_req(CMD_FETCH, 32'hffff_ffe0, 2'd2, '0, '0, 1'b0, 1'b0), 1'b0);
        // failed refill: erroring word, then a clean last word that must still fail
        send(make_req(CMD_FILL, 32'h0000_0000, SIZE_BYTE, 3'd0, 32'hffff_ffff, 1'b0, 1'b1),
             1'b0);
        send(make_req(CMD_FILL, 32'h0000_0000, SIZE_BYTE, 3'd7, 32'h1234_5678, 1'b1, 1'b0),
             1'b0);
        send(make_req(CMD_FETCH, 32'h0000_0000, 2'd2, '0, '0, 1'b0, 1'b0), 1'b0);
        send(make_req(CMD_INV_ALL, 32'h0000_0000, SIZE_BYTE, '0, '0, 1'b0, 1'b0), 1'b0);

        n_target = cmd_backlog.size() + N_RANDOM;
        while (cmd_backlog.size() < n_target)
        begin
            r = $urandom_range(99);
            if (r < 28)
            begin
                refill_line(pick_address(), $urandom_range(11) != 0);
            end
            else if (r < 78)
            begin
                a  = near_address();
                sz = 2'($urandom);
                if ($urandom_range(1) == 0)
                    a &= (sz == SIZE_BYTE) ? 32'hffff_ffff : (sz == SIZE_HALF) ? 32'hffff_fffe
                                                                                : 32'hffff_fffc;
                send(make_req(CMD_FETCH, a, sz, 3'($urandom), $urandom, 1'($urandom),
                              1'($urandom)), r >= 76);
            end
            else if (r < 88)
            begin
                a    = near_address();
                sz   = 2'($urandom);
                last = ($urandom_range(2) == 0);
                err  = ($urandom_range(2) == 0);
                r    = $urandom_range(7);
                if (last && !err && !line_complete(a, 3'(r)))
                    err = 1'b1;
                send(make_req(CMD_FILL, a, sz, 3'(r), $urandom, last, err), 1'b0);
            end
            else if (r < 97)
            begin
                send(make_req(CMD_INV_ADDR, near_address(), 2'($urandom), 3'($urandom),
                              $urandom, 1'($urandom), 1'($urandom)), 1'b0);
            end
            else
            begin
                send(make_req(CMD_INV_ALL, $urandom, 2'($urandom), 3'($urandom), $urandom,
                              1'($urandom), 1'($urandom)), 1'b0);
            end
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (cmd_backlog.size() != 0 || cmd_valid || rsp_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (n_errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
